>>> hdl/assert_macros.svh
// Shared assertion macros for the clock source divider select checks.
// Every macro samples on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CSDS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent that must be followed by the consequent in the next cycle.
`define CSDS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/csds_pkg.sv
`default_nettype none

package csds_pkg;

  // Sizes of the block
  localparam int MAX_SOURCES   = 6;
  localparam int MAX_DIVISOR   = 255;
  localparam int NUM_RATE_REGS = 6;
  localparam int NUM_SRC       = (MAX_SOURCES < NUM_RATE_REGS) ? MAX_SOURCES : NUM_RATE_REGS;

  // Field widths
  localparam int RATE_W        = 32;
  localparam int NUM_SOURCES_W = 3;
  localparam int MASK_W        = 6;
  localparam int SRC_OUT_W     = 3;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 32;

  // Internal widths
  localparam int SRC_CNT_W = $clog2(NUM_SRC + 1);
  localparam int IDX_W     = (NUM_SRC > 1) ? $clog2(NUM_SRC) : 1;
  localparam int DIV_CNT_W = $clog2(RATE_W);

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_SOURCES  = 4'd0,
    REG_PRESENT_MASK = 4'd1,
    REG_RATE_0       = 4'd2,
    REG_RATE_1       = 4'd3,
    REG_RATE_2       = 4'd4,
    REG_RATE_3       = 4'd5,
    REG_RATE_4       = 4'd6,
    REG_RATE_5       = 4'd7
  } cfg_reg_e;

endpackage

`default_nettype wire

>>> hdl/clock_source_divider_select.sv
// Clock source and divider select.
// Input channel (in_valid_i/in_ready_o) carries one requested rate per transfer;
// output channel (out_valid_o/out_ready_i) returns one result per request: found
// flag, winning source index, its rate and the divided rate floor(rate / div).
// Configuration channel (cfg_valid_i/cfg_ready_o) writes num_sources, the
// present mask and the six source rates; it is always ready and must only be
// used while no request is in flight.
// Timing: a request occupies the block from acceptance until its result is
// loaded into the output register. A source that is absent or slower than the
// request takes only a scan step; a candidate source takes a scan, a restoring
// division on the one shared divider, a check and, if the quotient is below
// MAX_DIVISOR, a second division and an update.
// in_ready_o is high only while idle, so at most one request is in progress.
// A finished result sits in the output register; if the receiver stalls, the
// block holds in its finish step until the output register frees up, and a new
// request may already be accepted while the previous result waits.
// Reset (rst_ni low, asynchronous) returns to idle, drops any pending result and
// restores num_sources = 1, present mask = all ones and all rates = 0.
`default_nettype none

module clock_source_divider_select (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [csds_pkg::RATE_W-1:0]     requested_rate_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 found_o,
  output logic [csds_pkg::SRC_OUT_W-1:0]       chosen_source_o,
  output logic [csds_pkg::RATE_W-1:0]          chosen_source_rate_o,
  output logic [csds_pkg::RATE_W-1:0]          achieved_rate_o,
  // configuration channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [csds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [csds_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import csds_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIV1,
    S_CHK,
    S_DIV2,
    S_UPD,
    S_FINISH
  } state_e;

  // Configuration registers
  logic [NUM_SOURCES_W-1:0] num_sources_q;
  logic [MASK_W-1:0]        present_mask_q;
  logic [RATE_W-1:0]        rate_q [NUM_SRC];

  // Sequencer and search state
  state_e                 state_q;
  logic [RATE_W-1:0]      req_q;
  logic [SRC_CNT_W-1:0]   src_q;
  logic [SRC_CNT_W-1:0]   src_lim_q;
  logic                   have_q;
  logic [SRC_OUT_W-1:0]   best_src_q;
  logic [RATE_W-1:0]      best_parent_q;
  logic [RATE_W-1:0]      best_rate_q;

  // Shared restoring divider: remainder, quotient/dividend shift register, divisor
  logic [RATE_W:0]        div_rem_q;
  logic [RATE_W-1:0]      div_quo_q;
  logic [RATE_W:0]        div_dvs_q;
  logic [DIV_CNT_W-1:0]   div_cnt_q;

  // Output register
  logic                   out_valid_q;
  logic                   found_q;
  logic [SRC_OUT_W-1:0]   chosen_source_q;
  logic [RATE_W-1:0]      chosen_source_rate_q;
  logic [RATE_W-1:0]      achieved_rate_q;

  logic [IDX_W-1:0]       src_idx;
  logic [RATE_W-1:0]      cur_rate;
  logic                   cur_present;
  logic [SRC_CNT_W-1:0]   count_sat;
  logic [RATE_W+1:0]      div_sh;
  logic [RATE_W+1:0]      div_diff;
  logic                   div_ge;
  logic [RATE_W:0]        div_rem_d;
  logic [RATE_W-1:0]      div_quo_d;
  logic                   div_last;
  logic                   upd_best;
  logic [CFG_IDX_W-1:0]   rate_sel;

  assign src_idx     = src_q[IDX_W-1:0];
  assign cur_rate    = rate_q[src_idx];
  assign cur_present = present_mask_q[src_idx];

  // Saturate the source count to the number of rate registers.
  assign count_sat = (SRC_CNT_W'(num_sources_q) > SRC_CNT_W'(NUM_SRC)) ?
                     SRC_CNT_W'(NUM_SRC) : SRC_CNT_W'(num_sources_q);

  // One quotient bit per cycle.
  assign div_sh    = {div_rem_q, div_quo_q[RATE_W-1]};
  assign div_diff  = div_sh - {1'b0, div_dvs_q};
  assign div_ge    = div_sh >= {1'b0, div_dvs_q};
  assign div_rem_d = div_ge ? div_diff[RATE_W:0] : div_sh[RATE_W:0];
  assign div_quo_d = {div_quo_q[RATE_W-2:0], div_ge};
  assign div_last  = (div_cnt_q == DIV_CNT_W'(RATE_W - 1));

  // Both candidates are at or below the request, so the closer one is the larger.
  assign upd_best = !have_q || (div_quo_q > best_rate_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign out_valid_o          = out_valid_q;
  assign found_o              = found_q;
  assign chosen_source_o      = chosen_source_q;
  assign chosen_source_rate_o = chosen_source_rate_q;
  assign achieved_rate_o      = achieved_rate_q;

  assign rate_sel = cfg_index_i - CFG_IDX_W'(REG_RATE_0);

  // Configuration writes; indexes beyond the map are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_sources_q  <= NUM_SOURCES_W'(1);
      present_mask_q <= '1;
      for (int i = 0; i < NUM_SRC; i++) begin
        rate_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_NUM_SOURCES) begin
        num_sources_q <= cfg_data_i[NUM_SOURCES_W-1:0];
      end else if (cfg_index_i == REG_PRESENT_MASK) begin
        present_mask_q <= cfg_data_i[MASK_W-1:0];
      end else if ((cfg_index_i >= REG_RATE_0) &&
                   (rate_sel < CFG_IDX_W'(NUM_RATE_REGS))) begin
        rate_q[rate_sel[IDX_W-1:0]] <= cfg_data_i[RATE_W-1:0];
      end
    end
  end

  // Sequencer: visit sources in order, up to two divisions per candidate.
  //   first division:  k = rate / (req + 1); divisor d = k + 1 if k < MAX_DIVISOR
  //   second division: achieved = rate / d
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q              <= S_IDLE;
      req_q                <= '0;
      src_q                <= '0;
      src_lim_q            <= '0;
      have_q               <= 1'b0;
      best_src_q           <= '0;
      best_parent_q        <= '0;
      best_rate_q          <= '0;
      div_rem_q            <= '0;
      div_quo_q            <= '0;
      div_dvs_q            <= '0;
      div_cnt_q            <= '0;
      out_valid_q          <= 1'b0;
      found_q              <= 1'b0;
      chosen_source_q      <= '0;
      chosen_source_rate_q <= '0;
      achieved_rate_q      <= '0;
    end else begin
      // drop the result once the receiver takes it; the finish step reloads it
      if (out_valid_q && out_ready_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q         <= requested_rate_i;
            src_q         <= '0;
            src_lim_q     <= count_sat;
            have_q        <= 1'b0;
            best_src_q    <= '0;
            best_parent_q <= '0;
            best_rate_q   <= '0;
            state_q       <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (src_q >= src_lim_q) begin
            state_q <= S_FINISH;
          end else if (!cur_present || (cur_rate < req_q)) begin
            src_q <= src_q + SRC_CNT_W'(1);
          end else begin
            div_rem_q <= '0;
            div_quo_q <= cur_rate;
            div_dvs_q <= {1'b0, req_q} + (RATE_W+1)'(1);
            div_cnt_q <= '0;
            state_q   <= S_DIV1;
          end
        end

        S_DIV1: begin
          div_rem_q <= div_rem_d;
          div_quo_q <= div_quo_d;
          div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
          if (div_last) begin
            state_q <= S_CHK;
          end
        end

        S_CHK: begin
          if (div_quo_q < RATE_W'(MAX_DIVISOR)) begin
            div_rem_q <= '0;
            div_dvs_q <= {1'b0, div_quo_q} + (RATE_W+1)'(1);
            div_quo_q <= cur_rate;
            div_cnt_q <= '0;
            state_q   <= S_DIV2;
          end else begin
            // even the largest divisor leaves the rate above the request
            src_q   <= src_q + SRC_CNT_W'(1);
            state_q <= S_SCAN;
          end
        end

        S_DIV2: begin
          div_rem_q <= div_rem_d;
          div_quo_q <= div_quo_d;
          div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
          if (div_last) begin
            state_q <= S_UPD;
          end
        end

        S_UPD: begin
          if (upd_best) begin
            have_q        <= 1'b1;
            best_src_q    <= SRC_OUT_W'(src_q);
            best_parent_q <= cur_rate;
            best_rate_q   <= div_quo_q;
          end
          // stop once the winner reaches zero
          if ((upd_best && (div_quo_q == '0)) || (!upd_best && (best_rate_q == '0))) begin
            state_q <= S_FINISH;
          end else begin
            src_q   <= src_q + SRC_CNT_W'(1);
            state_q <= S_SCAN;
          end
        end

        S_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q          <= 1'b1;
            found_q              <= have_q;
            chosen_source_q      <= best_src_q;
            chosen_source_rate_q <= best_parent_q;
            achieved_rate_q      <= best_rate_q;
            state_q              <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/csds_checker.sv
`default_nettype none
`include "assert_macros.svh"

module csds_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic                          found_o,
  input wire logic [csds_pkg::SRC_OUT_W-1:0] chosen_source_o,
  input wire logic [csds_pkg::RATE_W-1:0]    chosen_source_rate_o,
  input wire logic [csds_pkg::RATE_W-1:0]    achieved_rate_o
);
  import csds_pkg::*;

  // Hold a stalled result.
  `CSDS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  // Go busy right after a request transfer.
  `CSDS_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "ready after accepted request")

  // A miss reports all zeros.
  `CSDS_ASSERT(a_miss_zero, (out_valid_o && !found_o) |-> (chosen_source_o == '0 && chosen_source_rate_o == '0 && achieved_rate_o == '0), "miss with nonzero fields")

  // A hit names a real source and never divides the rate upward.
  `CSDS_ASSERT(a_hit_sane, (out_valid_o && found_o) |-> (chosen_source_o < SRC_OUT_W'(NUM_SRC) && achieved_rate_o <= chosen_source_rate_o), "hit with bad source or rate")

endmodule

bind clock_source_divider_select csds_checker u_csds_checker (.*);

`default_nettype wire
